// File: src/ett_pkg.sv
package ett_pkg;

	// request kinds carried on req_type
	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_CANCEL = 2'd2,
		REQ_TICK   = 2'd3
	} req_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [31:0] tag;
		logic [15:0] from_v;
		logic [15:0] to_v;
		logic [63:0] start_t;
		logic [31:0] dur;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// elapsed time has reached the duration (elapsed read as signed)
	function automatic logic el_done(input logic [63:0] el, input logic [31:0] dur);
		el_done = !el[63] && (el >= {32'd0, dur});
	endfunction

endpackage

// File: src/ett_ram.sv
module ett_ram #(
	parameter int W = 8,
	parameter int D = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                         wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                         rdata
);

	logic [W-1:0] mem_q [D];

	// write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/ett_div.sv
module ett_div #(
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   num,
	input  logic [31:0]   den,
	output logic          done,
	output logic [QW-1:0] quo
);

	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [32:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic          done_q;
	logic [32:0]   shl;
	logic [33:0]   diff;

	// one restoring step: shift remainder, try subtracting the divisor
	assign shl  = {rem_q[31:0], 1'b0};
	assign diff = {1'b0, shl} - {2'b00, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
				rem_q  <= {1'b0, num};
			end else if (busy_q) begin
				if (!diff[33]) begin
					rem_q <= diff[32:0];
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= shl;
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: src/eased_tween_table.sv
// Tween table: NUM_SLOTS animation tweens addressed by a 32-bit tag.
// Input channel (in_valid/in_ready) takes one request: start, query,
// cancel or tick. Output channel (out_valid/out_ready) returns exactly
// one item per request: value_out, in_progress, found, accepted.
// Each request first sweeps the slot memory, one slot per cycle. Start,
// cancel, tick and a missed query then present their item; a query that
// lands outside the tween first works out the elapsed time and checks it.
// A query inside the tween adds the bit-serial divider, three passes
// through the shared multiplier and a rounding step.
// in_ready is high only while the sequencer is idle; one request at a
// time, the next taken at the earliest once the previous item is
// presented. The finished item sits in the output register; while the
// receiver stalls a new request may be taken and worked, and its result
// waits until the previous item has gone.
// Reset clears all active marks and the handshake state; slot contents
// are undefined until a start writes them.
module eased_tween_table
	import ett_pkg::*;
#(
	parameter int NUM_SLOTS      = 8,
	parameter int EASE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [31:0]        tag,
	input  logic signed [15:0] from_value,
	input  logic signed [15:0] to_value,
	input  logic [31:0]        span_us,
	input  logic signed [63:0] now_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] value_out,
	output logic               in_progress,
	output logic               found,
	output logic               accepted
);

	localparam int F  = EASE_FRAC_BITS;
	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int MW = (F + 2 > 17) ? F + 2 : 17;
	localparam int PW = 2 * MW;
	localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);
	localparam logic [F:0] ONE  = (F+1)'(1) << F;
	localparam logic [F-1:0] HALF = F'(1) << (F - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_POST, S_EL, S_CHK, S_DIV, S_MUL, S_RND, S_OUT
	} state_t;

	state_t         state_q;
	req_t           req_q;
	logic [31:0]    tag_q;
	logic [15:0]    from_q, to_q;
	logic [31:0]    dur_q;
	logic [63:0]    now_q;
	logic [NUM_SLOTS-1:0] act_q;
	logic [AW-1:0]  idx_q, idx_s1;
	logic           pend_s1, issue_end_q;
	logic           hit_q, free_ok_q;
	logic [AW-1:0]  hit_idx_q, free_idx_q;
	slot_t          m_q;
	logic [63:0]    el_q;
	logic [F:0]     w_q;
	logic [1:0]     mstep_q;
	logic signed [PW-1:0] p_q;
	logic [15:0]    res_val_q;
	logic           res_prog_q, res_found_q, res_acc_q;
	logic           out_valid_q;
	logic [15:0]    ov_q;
	logic           op_q, of_q, oa_q;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	slot_t          ram_wdata, ram_rdata;
	logic           div_start, div_done;
	logic [F-1:0]   div_quo;
	logic [63:0]    scan_el;
	logic           scan_act;
	logic signed [MW-1:0] mul_a, mul_b;
	logic [F:0]     wn;
	logic signed [16:0] dft;
	logic signed [PW:0] qsum;
	logic signed [PW:0] qfl;
	logic [F-1:0]   qrem;
	logic           el_zn, el_dn;
	logic           out_load;

	ett_ram #(.W(SLOT_W), .D(NUM_SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	ett_div #(.QW(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (el_q[31:0]),
		.den    (m_q.dur),
		.done   (div_done),
		.quo    (div_quo)
	);

	// write the new tween after the sweep of a start
	always_comb begin
		ram_we          = (state_q == S_POST) && (req_q == REQ_START) && (hit_q || free_ok_q);
		ram_waddr       = hit_q ? hit_idx_q : free_idx_q;
		ram_wdata.tag     = tag_q;
		ram_wdata.from_v  = from_q;
		ram_wdata.to_v    = to_q;
		ram_wdata.start_t = now_q;
		ram_wdata.dur     = dur_q;
	end

	assign scan_el   = now_q - ram_rdata.start_t;
	assign scan_act  = act_q[idx_s1];
	assign div_start = (state_q == S_CHK) && !el_zn && !el_dn;
	assign el_zn     = (el_q == 64'd0) || el_q[63];
	assign el_dn     = el_done(el_q, m_q.dur);
	assign wn        = ONE - {1'b0, div_quo};
	assign dft       = 17'(signed'(m_q.to_v)) - 17'(signed'(m_q.from_v));
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// pick multiplier operands: w*w, then w2*w, then e*(to-from)
	always_comb begin
		case (mstep_q)
			2'd0: begin
				mul_a = signed'(MW'(w_q));
				mul_b = signed'(MW'(w_q));
			end
			2'd1: begin
				mul_a = signed'(MW'(p_q[2*F:F]));
				mul_b = signed'(MW'(w_q));
			end
			default: begin
				mul_a = signed'(MW'(ONE - p_q[2*F:F]));
				mul_b = MW'(dft);
			end
		endcase
	end

	// from scaled up plus the eased step, then split for rounding
	assign qsum = (PW+1)'(signed'(m_q.from_v)) * (PW+1)'(signed'({1'b0, ONE}))
		+ (PW+1)'(p_q);
	assign qfl  = qsum >>> F;
	assign qrem = qsum[F-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= '0;
			pend_s1     <= 1'b0;
			issue_end_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			mstep_q     <= '0;
		end else begin
			// present a finished item, drop it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// mark a slot read issued this cycle
			pend_s1 <= (state_q == S_SCAN) && !issue_end_q;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q       <= req_t'(req_type);
						tag_q       <= tag;
						from_q      <= from_value;
						to_q        <= to_value;
						dur_q       <= span_us;
						now_q       <= now_us;
						idx_q       <= '0;
						issue_end_q <= 1'b0;
						hit_q       <= 1'b0;
						free_ok_q   <= 1'b0;
						res_val_q   <= '0;
						res_prog_q  <= 1'b0;
						res_found_q <= 1'b0;
						res_acc_q   <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one slot read a cycle
					if (!issue_end_q) begin
						idx_s1  <= idx_q;
						if (idx_q == LAST) begin
							issue_end_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					// examine the slot read last cycle
					if (pend_s1) begin
						if (scan_act && ram_rdata.tag == tag_q && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
							m_q       <= ram_rdata;
						end
						if (!scan_act && !free_ok_q) begin
							free_ok_q  <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (req_q == REQ_TICK && scan_act &&
							el_done(scan_el, ram_rdata.dur)) begin
							act_q[idx_s1] <= 1'b0;
						end
						if (idx_s1 == LAST) begin
							state_q <= S_POST;
						end
					end
				end
				S_POST: begin
					if (req_q != REQ_TICK) begin
						res_found_q <= hit_q;
					end
					state_q <= S_OUT;
					case (req_q)
						REQ_START: begin
							if (hit_q || free_ok_q) begin
								act_q[ram_waddr] <= 1'b1;
								res_acc_q        <= 1'b1;
							end
						end
						REQ_CANCEL: begin
							if (hit_q) begin
								act_q[hit_idx_q] <= 1'b0;
							end
						end
						REQ_QUERY: begin
							if (hit_q) begin
								state_q <= S_EL;
							end
						end
						default: ;
					endcase
				end
				S_EL: begin
					el_q    <= now_q - m_q.start_t;
					state_q <= S_CHK;
				end
				S_CHK: begin
					res_prog_q <= !el_dn;
					if (el_zn) begin
						res_val_q <= m_q.from_v;
						state_q   <= S_OUT;
					end else if (el_dn) begin
						res_val_q <= m_q.to_v;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						w_q     <= wn;
						mstep_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					p_q <= PW'(mul_a * mul_b);
					if (mstep_q == 2'd2) begin
						state_q <= S_RND;
					end else begin
						mstep_q <= mstep_q + 1'b1;
					end
				end
				S_RND: begin
					// round to nearest, ties to even
					if (qrem > HALF || (qrem == HALF && qfl[0])) begin
						res_val_q <= qfl[15:0] + 16'd1;
					end else begin
						res_val_q <= qfl[15:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the previous item has left
					if (out_load) begin
						ov_q        <= res_val_q;
						op_q        <= res_prog_q;
						of_q        <= res_found_q;
						oa_q        <= res_acc_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign value_out   = signed'(ov_q);
	assign in_progress = op_q;
	assign found       = of_q;
	assign accepted    = oa_q;

endmodule

// File: src/ett_checker.sv
module ett_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] value_out,
	input logic        in_progress,
	input logic        found,
	input logic        accepted
);

	// a stalled item holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_out))
		else $error("output item changed while stalled");

	// progress (a query) and a write (a start) are never reported together
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(accepted && in_progress))
		else $error("progress and accepted together");

	// progress needs a found tween
	a_prog: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_progress |-> found)
		else $error("progress without a found tween");

	// a miss yields value zero
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> value_out == 16'd0)
		else $error("nonzero value on a miss");

endmodule

bind eased_tween_table ett_checker u_ett_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.value_out   (value_out),
	.in_progress (in_progress),
	.found       (found),
	.accepted    (accepted)
);

// File: tb/tb.sv
module tb;
	import ett_pkg::*;

	localparam int NSLOT = 8;
	localparam int FRAC = 16;
	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic [1:0] req_type = REQ_TICK;
	logic [31:0] tag = '0;
	logic signed [15:0] from_value = '0;
	logic signed [15:0] to_value = '0;
	logic [31:0] span_us = '0;
	logic signed [63:0] now_us = '0;
	logic in_ready, out_valid, in_progress, found, accepted;
	logic signed [15:0] value_out;

	eased_tween_table u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .tag(tag), .from_value(from_value), .to_value(to_value),
		.span_us(span_us), .now_us(now_us), .out_valid(out_valid),
		.out_ready(out_ready), .value_out(value_out), .in_progress(in_progress),
		.found(found), .accepted(accepted)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	typedef struct packed {
		logic [15:0] value;
		logic        prog;
		logic        hit;
		logic        taken;
	} tween_res_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] tg;
		logic [15:0] fv;
		logic [15:0] tv;
		logic [31:0] dur;
		logic [63:0] now;
		logic        known;
		tween_res_t  res;
	} tween_req_t;

	// model copy of the tween table
	bit          m_active [NSLOT];
	logic [31:0] m_tag    [NSLOT];
	logic [15:0] m_from   [NSLOT];
	logic [15:0] m_to     [NSLOT];
	logic [63:0] m_start  [NSLOT];
	logic [31:0] m_dur    [NSLOT];

	tween_res_t pending_res[$];
	int errors = 0;
	int cycles = 0;
	int idle_in = 0, idle_out = 0;

	function automatic bit span_done(logic [63:0] el, logic [31:0] dur);
		return !el[63] && el >= {32'd0, dur};
	endfunction

	function automatic int slot_of(logic [31:0] tg);
		for (int i = 0; i < NSLOT; i++)
			if (m_active[i] && m_tag[i] == tg) return i;
		return -1;
	endfunction

	function automatic logic [15:0] ease_at(int s, logic [63:0] el);
		logic [63:0] u, w, w2, w3, e, uq, fl, rem;
		logic signed [63:0] f, t, q;
		if (el == 0 || el[63]) return m_from[s];
		if (span_done(el, m_dur[s])) return m_to[s];
		u = (el << FRAC) / {32'd0, m_dur[s]};
		w = (64'd1 << FRAC) - u;
		w2 = (w * w) >> FRAC;
		w3 = (w2 * w) >> FRAC;
		e = (64'd1 << FRAC) - w3;
		f = {{48{m_from[s][15]}}, m_from[s]};
		t = {{48{m_to[s][15]}}, m_to[s]};
		q = f * (64'sd1 <<< FRAC) + $signed(e) * (t - f);
		uq = q + (64'd1 << (17 + FRAC));
		fl = uq >> FRAC;
		rem = uq & ((64'd1 << FRAC) - 1);
		if (rem > (64'd1 << (FRAC - 1)) || (rem == (64'd1 << (FRAC - 1)) && fl[0]))
			fl++;
		return 16'(fl - (64'd1 << 17));
	endfunction

	// advance the table model by one request and give its result
	function automatic tween_res_t tween_step(tween_req_t r);
		tween_res_t o;
		int s;
		logic [63:0] el;
		o = '0;
		case (r.kind)
			REQ_START: begin
				s = slot_of(r.tg);
				o.hit = (s >= 0);
				if (s < 0)
					for (int i = NSLOT - 1; i >= 0; i--) if (!m_active[i]) s = i;
				if (s >= 0) begin
					m_active[s] = 1; m_tag[s] = r.tg; m_from[s] = r.fv; m_to[s] = r.tv;
					m_start[s] = r.now; m_dur[s] = r.dur; o.taken = 1;
				end
			end
			REQ_QUERY: begin
				s = slot_of(r.tg);
				if (s >= 0) begin
					el = r.now - m_start[s];
					o.hit = 1;
					o.value = ease_at(s, el);
					o.prog = !span_done(el, m_dur[s]);
				end
			end
			REQ_CANCEL: begin
				s = slot_of(r.tg);
				if (s >= 0) begin
					o.hit = 1; m_active[s] = 0;
				end
			end
			default: begin
				for (int i = 0; i < NSLOT; i++)
					if (m_active[i] && span_done(r.now - m_start[i], m_dur[i]))
						m_active[i] = 0;
			end
		endcase
		return o;
	endfunction

	// check each result item as the receiver takes it
	always @(posedge clk) begin
		tween_res_t e, a;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			a = '{value_out, in_progress, found, accepted};
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected item %h", $time, a);
				errors++;
			end else begin
				e = pending_res.pop_front();
				if (e.value !== a.value) begin
					$display("%0t: value exp %h got %h", $time, e.value, a.value); errors++;
				end
				if (e.prog !== a.prog) begin
					$display("%0t: in_progress exp %b got %b", $time, e.prog, a.prog); errors++;
				end
				if (e.hit !== a.hit) begin
					$display("%0t: found exp %b got %b", $time, e.hit, a.hit); errors++;
				end
				if (e.taken !== a.taken) begin
					$display("%0t: accepted exp %b got %b", $time, e.taken, a.taken); errors++;
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= idle_out);

	// offer one item at a falling edge, idling at random first, and hold it until taken
	task automatic send_req(tween_req_t r);
		tween_res_t p;
		@(negedge clk);
		while ($urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_type <= r.kind; tag <= r.tg; from_value <= r.fv; to_value <= r.tv;
		span_us <= r.dur; now_us <= r.now; in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = tween_step(r);
		if (r.known && p !== r.res) begin
			$display("%0t: table row exp %h model %h", $time, r.res, p);
			errors++;
		end
		pending_res.push_back(p);
	endtask

	function automatic tween_req_t mk(logic [1:0] k, logic [31:0] tg, logic [15:0] fv,
			logic [15:0] tv, logic [31:0] dur, logic [63:0] now, logic kn, tween_res_t rs);
		tween_req_t r;
		r.kind = k; r.tg = tg; r.fv = fv; r.tv = tv; r.dur = dur; r.now = now;
		r.known = kn; r.res = rs;
		return r;
	endfunction

	tween_req_t dir_rows[$];
	logic [31:0] tag_pool[6] = '{32'd1, 32'd2, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd77};
	logic [63:0] clock_us;

	initial begin
		tween_req_t r;
		int k;
		// directed rows
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 0, 1, '{16'd0, 1'b0, 1'b0, 1'b0}));
		dir_rows.push_back(mk(REQ_CANCEL, 32'd5, 0, 0, 0, 0, 1, '{16'd0, 1'b0, 1'b0, 1'b0}));
		dir_rows.push_back(mk(REQ_START, 32'd5, 16'h8000, 16'h7FFF, 32'd1000, 64'd100, 1,
			'{16'd0, 1'b0, 1'b0, 1'b1}));
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 64'd50, 1, '{16'h8000, 1'b1, 1'b1, 1'b0}));
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 64'd100, 1, '{16'h8000, 1'b1, 1'b1, 1'b0}));
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 64'd600, 0, '0));
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 64'd1099, 0, '0));
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 64'd1100, 1, '{16'h7FFF, 1'b0, 1'b1, 1'b0}));
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 64'h8000_0000_0000_0000, 0, '0));
		dir_rows.push_back(mk(REQ_START, 32'd5, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF,
			64'h7FFF_FFFF_FFFF_FFFF, 1, '{16'd0, 1'b0, 1'b1, 1'b1}));
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 64'h8000_0000_0000_0000, 0, '0));
		dir_rows.push_back(mk(REQ_QUERY, 32'd5, 0, 0, 0, 64'h8000_0000_7FFF_FFFF, 0, '0));
		for (int i = 0; i < 8; i++)
			dir_rows.push_back(mk(REQ_START, 32'hFFFF_FFF0 + i, 16'd10, 16'hFFF6, 32'd0,
				64'd0, 0, '0));
		dir_rows.push_back(mk(REQ_START, 32'd9, 0, 0, 0, 0, 1, '{16'd0, 1'b0, 1'b0, 1'b0}));
		dir_rows.push_back(mk(REQ_QUERY, 32'hFFFF_FFF1, 0, 0, 0, 64'd0, 0, '0));
		dir_rows.push_back(mk(REQ_QUERY, 32'hFFFF_FFF1, 0, 0, 0, 64'd1, 0, '0));
		dir_rows.push_back(mk(REQ_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
			64'd0, 1, '0));
		dir_rows.push_back(mk(REQ_CANCEL, 32'd5, 0, 0, 0, 0, 1, '{16'd0, 1'b0, 1'b1, 1'b0}));
		dir_rows.push_back(mk(REQ_QUERY, 32'hFFFF_FFF1, 0, 0, 0, 64'd1, 1, '0));

		for (int i = 0; i < NSLOT; i++) m_active[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) send_req(dir_rows[i]);
		@(negedge clk);
		in_valid <= 1'b0;

		// hold off until the table has drained
		wait (pending_res.size() == 0);
		repeat (40) @(negedge clk);

		// random phases with different idling
		clock_us = 64'd1000;
		for (int ph = 0; ph < 3; ph++) begin
			idle_in = (ph == 0) ? 11 : (ph == 1) ? 71 : 0;
			idle_out = (ph == 0) ? 71 : (ph == 1) ? 11 : 0;
			for (int n = 0; n < 135; n++) begin
				k = $urandom_range(99);
				clock_us = clock_us + $urandom_range(300);
				r = mk(REQ_QUERY, tag_pool[$urandom_range(5)], 16'($urandom), 16'($urandom),
					$urandom_range(2000), clock_us, 0, '0);
				if ($urandom_range(9) == 0) r.tg = $urandom;
				if ($urandom_range(9) == 0) r.dur = $urandom;
				if ($urandom_range(19) == 0) r.now = {$urandom, $urandom};
				if (k < 30) r.kind = REQ_START;
				else if (k < 80) r.kind = REQ_QUERY;
				else if (k < 90) r.kind = REQ_CANCEL;
				else r.kind = REQ_TICK;
				send_req(r);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		wait (pending_res.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
